// File: rtl/aes_pkg.sv
// Package with AES types, constants and byte-level functions.
package aes_pkg;

    localparam int unsigned MaxRoundsDefault = 14;
    localparam int unsigned CfgIdxWidth      = 3;
    localparam int unsigned CfgDataWidth     = 64;

    localparam logic [CfgIdxWidth-1:0] CFG_KEY_SIZE = 3'd0;
    localparam logic [CfgIdxWidth-1:0] CFG_KEY_A    = 3'd1;
    localparam logic [CfgIdxWidth-1:0] CFG_KEY_B    = 3'd2;
    localparam logic [CfgIdxWidth-1:0] CFG_KEY_C    = 3'd3;
    localparam logic [CfgIdxWidth-1:0] CFG_KEY_D    = 3'd4;

    localparam logic [1:0] KEY_128 = 2'd0;
    localparam logic [1:0] KEY_192 = 2'd1;

    localparam logic FUNC_ENC = 1'b0;

    typedef struct packed {
        logic        func;
        logic [63:0] block_high;
        logic [63:0] block_low;
    } t_in_beat;

    typedef struct packed {
        logic [63:0] out_high;
        logic [63:0] out_low;
    } t_out_beat;

    // Controller to datapath commands.
    typedef struct packed {
        logic capture;    // register the accepted input block
        logic key_start;  // begin expansion
        logic key_step;   // produce one expanded word
        logic load;       // load input block and apply first round key
        logic round;      // one middle round
        logic last;       // final round
        logic inverse;    // decrypt direction
    } t_cmd;

    // Datapath to controller status.
    typedef struct packed {
        logic key_done;
    } t_status;

    localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    localparam logic [7:0] INV_SBOX [256] = '{
    8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
    8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
    8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
    8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
    8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
    8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
    8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
    8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
    8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
    8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
    8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
    8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
    8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
    8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
    8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
    8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
    };

    function automatic logic [7:0] xt(input logic [7:0] b);
        xt = {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [31:0] sub_word(input logic [31:0] w);
        sub_word = {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
    endfunction

endpackage

// File: rtl/aes_block_cipher.sv
// AES block cipher top level: configuration registers, controller and datapath.
//
// Usage: key_size and the four key parts are written through the plain
// configuration port (i_cfg_we, i_cfg_index, i_cfg_data) while the block is
// idle. A write to one of these registers marks the expanded key stale. A
// block beat enters on the input channel (valid/ready) with func selecting
// encrypt or decrypt, and one result beat leaves on the output channel.
// The first block after reset or after a configuration write first runs the
// key expansion, one round-key word per cycle. The block is captured on
// acceptance; its first round key is then fetched and applied on load, and
// its middle rounds and final round run in turn on the shared round unit.
// The result is held in the state register while the receiver stalls; no new
// block is accepted until the result beat is taken.
// Reset clears the key registers to zero, selects the 128-bit key size and
// marks the round-key store stale; the store itself is not cleared.
module aes_block_cipher #(
    parameter int unsigned MAX_ROUNDS = aes_pkg::MaxRoundsDefault
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [aes_pkg::CfgIdxWidth-1:0]      i_cfg_index,
    input  logic [aes_pkg::CfgDataWidth-1:0]     i_cfg_data,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  aes_pkg::t_in_beat                    i_in,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output aes_pkg::t_out_beat                   o_out
);
    import aes_pkg::*;

    localparam int unsigned AW = $clog2(4 * (MAX_ROUNDS + 1));

    logic [1:0]   r_key_size;
    logic [255:0] r_key;
    logic         cfg_hit;
    t_cmd         cmd;
    t_status      status;
    logic [AW-1:0] rk_addr;
    logic [127:0] state;

    // Writes to an index beyond the register list change nothing.
    always_comb begin
        case (i_cfg_index)
            CFG_KEY_SIZE, CFG_KEY_A, CFG_KEY_B, CFG_KEY_C, CFG_KEY_D: cfg_hit = i_cfg_we;
            default: cfg_hit = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_size <= KEY_128;
            r_key      <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_KEY_SIZE: r_key_size <= i_cfg_data[1:0];
                CFG_KEY_A:    r_key[255:192] <= i_cfg_data;
                CFG_KEY_B:    r_key[191:128] <= i_cfg_data;
                CFG_KEY_C:    r_key[127:64]  <= i_cfg_data;
                CFG_KEY_D:    r_key[63:0]    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    aes_ctrl #(.MAX_ROUNDS(MAX_ROUNDS)) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_hit),
        .i_key_size  (r_key_size),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_func   (i_in.func),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_status    (status),
        .o_cmd       (cmd),
        .o_rk_addr   (rk_addr)
    );

    aes_datapath #(.MAX_ROUNDS(MAX_ROUNDS)) u_dp (
        .i_clk      (i_clk),
        .i_key_size (r_key_size),
        .i_key      (r_key),
        .i_cmd      (cmd),
        .i_rk_addr  (rk_addr),
        .i_in       (i_in),
        .o_status   (status),
        .o_state    (state)
    );

    assign o_out.out_high = state[127:64];
    assign o_out.out_low  = state[63:0];

`ifndef SYNTHESIS
    // A result beat is never offered while a new block can be taken.
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_out_valid && o_in_ready))
        else $error("result valid while input ready");

    // Acceptance of a block is always followed by a busy cycle.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("ready stayed high after accept");

    // Taking a result returns the block to idle.
    a_idle_after_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready) |=> (o_in_ready && !o_out_valid))
        else $error("not idle after result taken");
`endif
endmodule

// File: rtl/aes_ram.sv
// Generic single-port-write, registered-read RAM.
module aes_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// File: rtl/aes_datapath.sv
// AES datapath: key expansion unit, round-key store and shared round unit.
module aes_datapath #(
    parameter int unsigned MAX_ROUNDS = aes_pkg::MaxRoundsDefault
) (
    input  logic              i_clk,
    input  logic [1:0]        i_key_size,
    input  logic [255:0]      i_key,
    input  aes_pkg::t_cmd     i_cmd,
    input  logic [$clog2(4*(MAX_ROUNDS+1))-1:0] i_rk_addr,
    input  aes_pkg::t_in_beat i_in,
    output aes_pkg::t_status  o_status,
    output logic [127:0]      o_state
);
    import aes_pkg::*;

    localparam int unsigned KeyWords = 4 * (MAX_ROUNDS + 1);
    localparam int unsigned AW       = $clog2(KeyWords);

    // Round key words live in four RAMs, one per column, so all four words of a
    // round key are read together.
    localparam int unsigned RkDepth = MAX_ROUNDS + 1;
    localparam int unsigned RW      = $clog2(RkDepth);

    logic [3:0]   nk;
    logic [AW:0]  total;
    logic [AW:0]  r_idx;
    logic [3:0]   r_ctr;     // i mod nk
    logic [7:0]   r_rc;
    logic [255:0] r_win;     // last eight words, newest in low word
    logic [31:0]  w_prev, w_nk, t_word, new_word;
    logic         w_write;
    logic [3:0]   nr;
    logic [3:0]   nr_cap;

    always_comb begin
        case (i_key_size)
            KEY_128: nk = 4'd4;
            KEY_192: nk = 4'd6;
            default: nk = 4'd8;
        endcase
        nr = nk + 4'd6;
        nr_cap = (32'(nr) > MAX_ROUNDS) ? 4'(MAX_ROUNDS) : nr;
        total = (AW+1)'(4 * (32'(nr_cap) + 1));
    end

    assign w_prev = r_win[31:0];
    always_comb begin
        case (nk)
            4'd4:    w_nk = r_win[127:96];
            4'd6:    w_nk = r_win[191:160];
            default: w_nk = r_win[255:224];
        endcase
        if (r_ctr == 4'd0) begin
            t_word = sub_word({w_prev[23:0], w_prev[31:24]}) ^ {r_rc, 24'h0};
        end else if (nk == 4'd8 && r_ctr == 4'd4) begin
            t_word = sub_word(w_prev);
        end else begin
            t_word = w_prev;
        end
        if (r_idx < (AW+1)'(nk)) begin
            new_word = i_key[255 - 32*r_idx[2:0] -: 32];
        end else begin
            new_word = w_nk ^ t_word;
        end
    end

    assign w_write = i_cmd.key_step && (r_idx < total);
    assign o_status.key_done = (r_idx >= total);

    always_ff @(posedge i_clk) begin
        if (i_cmd.key_start) begin
            r_idx <= '0;
            r_ctr <= '0;
            r_rc  <= 8'h01;
        end else if (w_write) begin
            r_idx <= r_idx + 1'b1;
            r_win <= {r_win[223:0], new_word};
            if (r_idx >= (AW+1)'(nk)) begin
                if (r_ctr == 4'd0) begin
                    r_rc <= xt(r_rc);
                end
            end
            r_ctr <= (r_ctr == nk - 4'd1) ? 4'd0 : r_ctr + 4'd1;
        end
    end

    logic [31:0] rk_col [4];
    logic [RW-1:0] rd_row;
    assign rd_row = RW'(i_rk_addr >> 2);

    for (genvar c = 0; c < 4; c++) begin : g_col
        aes_ram #(.WIDTH(32), .DEPTH(RkDepth)) u_ram (
            .i_clk   (i_clk),
            .i_we    (w_write && r_idx[1:0] == 2'(c)),
            .i_waddr (RW'(r_idx >> 2)),
            .i_wdata (new_word),
            .i_raddr (rd_row),
            .o_rdata (rk_col[c])
        );
    end

    logic [127:0] rk;
    assign rk = {rk_col[0], rk_col[1], rk_col[2], rk_col[3]};

    // The accepted block is held here until the first round key arrives.
    logic [127:0] r_blk;
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_blk <= {i_in.block_high, i_in.block_low};
        end
    end

    // Round unit. Byte n of the block sits at bits 127-8n.
    logic [127:0] r_st, sb, sr, mc, rnd;
    logic [7:0]   a [16];
    logic [7:0]   b [16];

    always_comb begin
        for (int n = 0; n < 16; n++) begin
            a[n] = r_st[127-8*n -: 8];
        end
        // Forward: SubBytes then ShiftRows. Inverse: InvShiftRows then InvSubBytes.
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                if (i_cmd.inverse) begin
                    b[r + 4*((c + r) & 3)] = INV_SBOX[a[r + 4*c]];
                end else begin
                    b[r + 4*c] = SBOX[a[r + 4*((c + r) & 3)]];
                end
            end
        end
        for (int n = 0; n < 16; n++) begin
            sr[127-8*n -: 8] = b[n];
        end
        sb = sr;
    end

    // Forward or inverse MixColumns on one column.
    function automatic logic [31:0] mix_col(input logic [31:0] col, input logic inv);
        logic [7:0] x [4];
        logic [7:0] x2 [4];
        logic [7:0] x4 [4];
        logic [7:0] x8 [4];
        logic [7:0] o [4];
        for (int k = 0; k < 4; k++) begin
            x[k]  = col[31-8*k -: 8];
            x2[k] = xt(x[k]);
            x4[k] = xt(x2[k]);
            x8[k] = xt(x4[k]);
        end
        for (int r = 0; r < 4; r++) begin
            if (inv) begin
                o[r] = (x8[r] ^ x4[r] ^ x2[r])
                     ^ (x8[(r+1)&3] ^ x2[(r+1)&3] ^ x[(r+1)&3])
                     ^ (x8[(r+2)&3] ^ x4[(r+2)&3] ^ x[(r+2)&3])
                     ^ (x8[(r+3)&3] ^ x[(r+3)&3]);
            end else begin
                o[r] = x2[r] ^ (x2[(r+1)&3] ^ x[(r+1)&3]) ^ x[(r+2)&3] ^ x[(r+3)&3];
            end
        end
        mix_col = {o[0], o[1], o[2], o[3]};
    endfunction

    always_comb begin
        for (int c = 0; c < 4; c++) begin
            mc[127-32*c -: 32] = mix_col(sb[127-32*c -: 32], 1'b0);
        end
        if (i_cmd.inverse) begin
            // Inverse round: shift, sub, add key, then InvMixColumns.
            for (int c = 0; c < 4; c++) begin
                rnd[127-32*c -: 32] = mix_col(sb[127-32*c -: 32] ^ rk[127-32*c -: 32], 1'b1);
            end
        end else begin
            rnd = mc ^ rk;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_st <= r_blk ^ rk;
        end else if (i_cmd.round) begin
            r_st <= rnd;
        end else if (i_cmd.last) begin
            r_st <= sb ^ rk;
        end
    end

    assign o_state = r_st;
endmodule

// File: rtl/aes_ctrl.sv
// AES controller: key expansion sequencing and round sequencing.
module aes_ctrl #(
    parameter int unsigned MAX_ROUNDS = aes_pkg::MaxRoundsDefault
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [1:0]       i_key_size,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  logic             i_in_func,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    input  aes_pkg::t_status i_status,
    output aes_pkg::t_cmd    o_cmd,
    output logic [$clog2(4*(MAX_ROUNDS+1))-1:0] o_rk_addr
);
    import aes_pkg::*;

    localparam int unsigned AW = $clog2(4 * (MAX_ROUNDS + 1));
    localparam int unsigned RCW = $clog2(MAX_ROUNDS + 1);

    typedef enum logic [2:0] {
        S_IDLE, S_KSTART, S_KEXP, S_FETCH, S_LOAD, S_ROUND, S_LAST, S_OUT
    } t_state;

    t_state         r_state;
    logic           r_keys_ready;
    logic           r_inv;
    logic [RCW-1:0] r_rnd;
    logic [RCW-1:0] nr;
    logic [3:0]     nr_full;

    always_comb begin
        case (i_key_size)
            KEY_128: nr_full = 4'd10;
            KEY_192: nr_full = 4'd12;
            default: nr_full = 4'd14;
        endcase
        nr = (32'(nr_full) > MAX_ROUNDS) ? RCW'(MAX_ROUNDS) : RCW'(nr_full);
    end

    // Round key index used in the current (or next) round.
    logic [RCW-1:0] key_row;
    always_comb begin
        key_row = r_inv ? (nr - r_rnd) : r_rnd;
        o_rk_addr = AW'({key_row, 2'b00});
    end

    always_comb begin
        o_cmd = '0;
        o_cmd.capture   = (r_state == S_IDLE) && i_in_valid;
        o_cmd.inverse   = r_inv;
        o_cmd.key_start = (r_state == S_KSTART);
        o_cmd.key_step  = (r_state == S_KEXP);
        o_cmd.load      = (r_state == S_LOAD);
        o_cmd.round     = (r_state == S_ROUND);
        o_cmd.last      = (r_state == S_LAST);
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_OUT);

    // The round key for round r is fetched ahead (registered RAM read), so in
    // S_FETCH, S_LOAD and S_ROUND r_rnd names the key consumed in the next cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_keys_ready <= 1'b0;
            r_inv        <= 1'b0;
            r_rnd        <= '0;
        end else begin
            if (i_cfg_we) begin
                r_keys_ready <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    r_rnd <= '0;
                    if (i_in_valid) begin
                        r_inv   <= (i_in_func != FUNC_ENC);
                        r_state <= r_keys_ready ? S_FETCH : S_KSTART;
                    end
                end
                S_KSTART: r_state <= S_KEXP;
                S_KEXP: begin
                    if (i_status.key_done) begin
                        r_keys_ready <= 1'b1;
                        r_state      <= S_FETCH;
                    end
                end
                S_FETCH: begin
                    r_rnd   <= r_rnd + 1'b1;
                    r_state <= S_LOAD;
                end
                S_LOAD: begin
                    r_rnd   <= r_rnd + 1'b1;
                    r_state <= (r_rnd == nr) ? S_LAST : S_ROUND;
                end
                S_ROUND: begin
                    r_rnd <= r_rnd + 1'b1;
                    if (r_rnd == nr) begin
                        r_state <= S_LAST;
                    end
                end
                S_LAST: r_state <= S_OUT;
                S_OUT: begin
                    if (i_out_ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

// File: tb/tb.sv
// Self-checking testbench for the AES block cipher with 128-, 192- and 256-bit keys.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import aes_pkg::*;

    // The watchdog limit covers the longest key expansion and long stall runs.
    localparam int unsigned StallLimit = 5000;
    localparam int unsigned MaxReport  = 10;

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    cfg_we;
    logic [CfgIdxWidth-1:0]  cfg_index;
    logic [CfgDataWidth-1:0] cfg_data;
    logic                    in_valid;
    logic                    o_in_ready;
    t_in_beat                in_beat;
    logic                    o_out_valid;
    logic                    out_ready;
    t_out_beat               o_out;

    aes_block_cipher uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (in_beat),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out       (o_out)
    );

    // Clock with a 10 ns period.
    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // The forward S-box of FIPS-197; the inverse box is derived from it at start.
    logic [7:0] fwd_sbox [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };
    logic [7:0] inv_sbox [256];

    // Shadow copy of the configuration and the expanded key schedule.
    logic [1:0]  shadow_key_size;
    logic [63:0] shadow_key_part [4];
    logic [31:0] round_keys [60];
    int unsigned cipher_rounds;

    // Blocks waiting to be sent, and the cipher results still to arrive.
    t_in_beat  block_q [$];
    t_out_beat cipher_results_q [$];

    int unsigned send_idle_pct;
    int unsigned recv_stall_pct;
    int unsigned mismatches;
    int unsigned quiet_cycles;

    function automatic logic [7:0] gf_double(input logic [7:0] b);
        return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] acc;
        acc = 8'h00;
        for (int i = 0; i < 8; i++) begin
            if (b[i]) acc ^= a;
            a = gf_double(a);
        end
        return acc;
    endfunction

    function automatic logic [31:0] sbox_word(input logic [31:0] w);
        return {fwd_sbox[w[31:24]], fwd_sbox[w[23:16]], fwd_sbox[w[15:8]], fwd_sbox[w[7:0]]};
    endfunction

    // Recompute the key schedule from the shadow key. Size three acts as 256 bits.
    function automatic void rebuild_schedule();
        int unsigned nk;
        int unsigned total;
        logic [7:0]  rcon;
        logic [31:0] t;
        nk = (shadow_key_size == KEY_128) ? 4 : ((shadow_key_size == KEY_192) ? 6 : 8);
        cipher_rounds = (nk + 6 > MaxRoundsDefault) ? MaxRoundsDefault : nk + 6;
        total = 4 * (cipher_rounds + 1);
        rcon = 8'h01;
        for (int unsigned i = 0; i < total; i++) begin
            if (i < nk) begin
                round_keys[i] = i[0] ? shadow_key_part[i >> 1][31:0]
                                     : shadow_key_part[i >> 1][63:32];
            end else begin
                t = round_keys[i - 1];
                if (i % nk == 0) begin
                    t = sbox_word({t[23:0], t[31:24]}) ^ {rcon, 24'h0};
                    rcon = gf_double(rcon);
                end else if (nk > 6 && i % nk == 4) begin
                    t = sbox_word(t);
                end
                round_keys[i] = round_keys[i - nk] ^ t;
            end
        end
    endfunction

    // Byte i of the state sits at bits 127-8i down, i.e. byte 0 leads.
    function automatic logic [127:0] round_key(input int unsigned r);
        return {round_keys[4*r], round_keys[4*r+1], round_keys[4*r+2], round_keys[4*r+3]};
    endfunction

    function automatic logic [127:0] sub_bytes(input logic [127:0] s, input logic dec);
        for (int i = 0; i < 16; i++)
            s[127-8*i -: 8] = dec ? inv_sbox[s[127-8*i -: 8]] : fwd_sbox[s[127-8*i -: 8]];
        return s;
    endfunction

    // Row r of column c takes the byte from column c+r (forward) or gives it there.
    function automatic logic [127:0] shift_rows(input logic [127:0] s, input logic dec);
        logic [127:0] t;
        int          other;
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                other = r + 4 * ((c + r) % 4);
                if (dec) t[127-8*other -: 8] = s[127-8*(r+4*c) -: 8];
                else     t[127-8*(r+4*c) -: 8] = s[127-8*other -: 8];
            end
        end
        return t;
    endfunction

    function automatic logic [127:0] mix_columns(input logic [127:0] s, input logic dec);
        logic [7:0]   coef [4];
        logic [7:0]   acc;
        logic [127:0] t;
        if (dec) coef = '{8'd14, 8'd11, 8'd13, 8'd9};
        else     coef = '{8'd2, 8'd3, 8'd1, 8'd1};
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                acc = 8'h00;
                for (int k = 0; k < 4; k++)
                    acc ^= gf_mul(s[127-8*(4*c+k) -: 8], coef[(k + 4 - r) % 4]);
                t[127-8*(4*c+r) -: 8] = acc;
            end
        end
        return t;
    endfunction

    // Full cipher or inverse cipher of one block under the current schedule.
    function automatic t_out_beat cipher_block(input t_in_beat b);
        logic [127:0] s;
        t_out_beat    res;
        s = {b.block_high, b.block_low};
        if (b.func == FUNC_ENC) begin
            s ^= round_key(0);
            for (int unsigned r = 1; r < cipher_rounds; r++)
                s = mix_columns(shift_rows(sub_bytes(s, 1'b0), 1'b0), 1'b0) ^ round_key(r);
            s = shift_rows(sub_bytes(s, 1'b0), 1'b0) ^ round_key(cipher_rounds);
        end else begin
            s ^= round_key(cipher_rounds);
            for (int unsigned r = cipher_rounds - 1; r > 0; r--)
                s = mix_columns(sub_bytes(shift_rows(s, 1'b1), 1'b1) ^ round_key(r), 1'b1);
            s = sub_bytes(shift_rows(s, 1'b1), 1'b1) ^ round_key(0);
        end
        res.out_high = s[127:64];
        res.out_low  = s[63:0];
        return res;
    endfunction

    // Driver: presents queued blocks, idling at random between beats.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && o_in_ready) begin
                cipher_results_q.insert(cipher_results_q.size(), cipher_block(in_beat));
            end
            if (!in_valid || o_in_ready) begin
                if (block_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    in_beat  <= block_q.pop_front();
                    in_valid <= 1'b1;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // The receiver stalls at random according to the phase.
    always @(posedge i_clk) begin
        if (!i_rst_n) out_ready <= 1'b0;
        else          out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Monitor: every result beat is checked against the oldest expectation.
    always @(posedge i_clk) begin
        t_out_beat want;
        if (i_rst_n && o_out_valid && out_ready) begin
            if (cipher_results_q.size() == 0) begin
                mismatches++;
                if (mismatches <= MaxReport)
                    $display("unexpected result beat %h_%h", o_out.out_high, o_out.out_low);
            end else begin
                want = cipher_results_q.pop_front();
                if (o_out.out_high !== want.out_high || o_out.out_low !== want.out_low) begin
                    mismatches++;
                    if (mismatches <= MaxReport)
                        $display("result mismatch: expected %h_%h, got %h_%h",
                                 want.out_high, want.out_low, o_out.out_high, o_out.out_low);
                end
            end
        end
    end

    // Watchdog: counts cycles in which no beat moves on either channel.
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_valid && o_in_ready) || (o_out_valid && out_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= StallLimit) begin
            $display("tb failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Register write through the plain port; the shadow follows the same rules.
    task automatic write_reg(input logic [CfgIdxWidth-1:0] idx, input logic [63:0] data);
        @(posedge i_clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        case (idx)
            CFG_KEY_SIZE: shadow_key_size = data[1:0];
            CFG_KEY_A:    shadow_key_part[0] = data;
            CFG_KEY_B:    shadow_key_part[1] = data;
            CFG_KEY_C:    shadow_key_part[2] = data;
            CFG_KEY_D:    shadow_key_part[3] = data;
            default: ;  // indexes past the last register change nothing
        endcase
        rebuild_schedule();
        @(posedge i_clk);
        cfg_we <= 1'b0;
    endtask

    task automatic load_key(input logic [1:0] size, input logic [63:0] a, input logic [63:0] b,
                            input logic [63:0] c, input logic [63:0] d);
        write_reg(CFG_KEY_SIZE, {$urandom, $urandom} & ~64'h3 | size);
        write_reg(CFG_KEY_A, a);
        write_reg(CFG_KEY_B, b);
        write_reg(CFG_KEY_C, c);
        write_reg(CFG_KEY_D, d);
    endtask

    // Waits until every queued block has left and its result has come back.
    task automatic drain();
        while (block_q.size() != 0 || in_valid || cipher_results_q.size() != 0)
            @(posedge i_clk);
        repeat (25) @(posedge i_clk);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    task automatic queue_block(input logic func, input logic [63:0] hi, input logic [63:0] lo);
        t_in_beat b;
        b.func       = func;
        b.block_high = hi;
        b.block_low  = lo;
        block_q.insert(block_q.size(), b);
    endtask

    // Random blocks; a share are sparse or saturated patterns to stress byte extremes.
    task automatic queue_random(input int unsigned count);
        logic [63:0] hi;
        logic [63:0] lo;
        for (int unsigned n = 0; n < count; n++) begin
            hi = rand64();
            lo = rand64();
            case ($urandom_range(7))
                0: begin hi &= rand64(); lo &= rand64(); end
                1: begin hi |= rand64(); lo |= rand64(); end
                default: ;
            endcase
            queue_block(1'($urandom_range(1)), hi, lo);
        end
    endtask

    initial begin
        i_rst_n        = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = CFG_KEY_SIZE;
        cfg_data       = '0;
        in_valid       = 1'b0;
        in_beat        = '0;
        out_ready      = 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        mismatches     = 0;
        quiet_cycles   = 0;
        for (int i = 0; i < 256; i++) inv_sbox[fwd_sbox[i]] = i[7:0];
        // After reset the key is all zero with a 128-bit size.
        shadow_key_size = KEY_128;
        for (int i = 0; i < 4; i++) shadow_key_part[i] = '0;
        rebuild_schedule();

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Blocks sent before any key write use the all-zero key.
        queue_block(FUNC_ENC, '0, '0);
        queue_block(~FUNC_ENC, '0, '0);
        queue_block(FUNC_ENC, '1, '1);
        queue_block(~FUNC_ENC, '1, '1);
        drain();

        // FIPS-197 example key and plaintext for each key size, both directions.
        for (int sz = 0; sz < 3; sz++) begin
            load_key(sz[1:0], 64'h0001020304050607, 64'h08090a0b0c0d0e0f,
                     64'h1011121314151617, 64'h18191a1b1c1d1e1f);
            queue_block(FUNC_ENC, 64'h0011223344556677, 64'h8899aabbccddeeff);
            queue_block(~FUNC_ENC, 64'h0011223344556677, 64'h8899aabbccddeeff);
            queue_block(FUNC_ENC, '1, '0);
            drain();
        end

        // Key size three saturates to a 256-bit key; all-ones key parts.
        load_key(2'd3, '1, '1, '1, '1);
        queue_block(FUNC_ENC, '0, '1);
        queue_block(~FUNC_ENC, '1, '0);
        drain();

        // A 128-bit key ignores parts C and D, and out-of-range writes do nothing.
        load_key(KEY_128, '1, '0, rand64(), rand64());
        for (int i = 5; i < 8; i++) write_reg(i[CfgIdxWidth-1:0], rand64());
        queue_block(FUNC_ENC, 64'h8000000000000000, 64'h1);
        queue_block(~FUNC_ENC, 64'h8000000000000000, 64'h1);
        drain();

        // Random phases: a random key size under each idling pattern.
        for (int ph = 0; ph < 12; ph++) begin
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 86; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 86; end
                default: begin send_idle_pct = 24; recv_stall_pct = 24; end
            endcase
            load_key(2'($urandom_range(3)), rand64(), rand64(), rand64(), rand64());
            queue_random(120);
            drain();
        end

        if (cipher_results_q.size() != 0) mismatches++;
        if (mismatches == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end

endmodule

// File: sim.f
rtl/aes_pkg.sv
rtl/aes_ram.sv
rtl/aes_datapath.sv
rtl/aes_ctrl.sv
rtl/aes_block_cipher.sv
tb/tb.sv
